// ===== rtl/core/rmsn_pkg.sv =====
// Shared constants, command and status types for the RMS normalization unit.
package rmsn_pkg;

    localparam int MAX_LEN    = 4096;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int DATA_W     = 16;
    localparam int SUM_W      = 48;
    localparam int EPS_W      = 16;
    localparam int INV_W      = 32;
    localparam int DIV_W      = 57;
    localparam int DVS_W      = 49;
    localparam int DIV_STEPS  = 57;
    localparam int DIV_CNT_W  = 6;
    localparam int SQRT_STEPS = 29;
    localparam int SQRT_CNT_W = 5;
    localparam int PROD_W     = 63;

    localparam logic [LEN_W-1:0] VLEN_RESET = LEN_W'(4096);
    localparam logic [EPS_W-1:0] EPS_RESET  = EPS_W'(17);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON       = 1'b1;

    localparam logic CMD_ACCUMULATE = 1'b0;
    localparam logic CMD_SCALE      = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,
        OP_MEAN_START,
        OP_DIV_STEP,
        OP_INV_START,
        OP_SQRT_START,
        OP_SQRT_STEP,
        OP_SQRT_END,
        OP_READ,
        OP_MUL_GX,
        OP_MUL_INV,
        OP_OUT
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAN_START,
        ST_DIV_MEAN,
        ST_INV_START,
        ST_DIV_INV,
        ST_SQRT_START,
        ST_SQRT,
        ST_SQRT_END,
        ST_GX,
        ST_MAG,
        ST_OUT
    } t_ctrl_state;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic scaling;
        logic acc_done;
        logic div_last;
        logic m_zero;
        logic sqrt_last;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/rmsn_if.sv =====
// Valid/ready channel interfaces for input items and result items.
interface rmsn_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] element_value;

    modport source (output valid, output command, output element_value, input ready);
    modport sink   (input valid, input command, input element_value, output ready);
endinterface

interface rmsn_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] normalized_value;
    logic        last_result;

    modport source (output valid, output normalized_value, output last_result, input ready);
    modport sink   (input valid, input normalized_value, input last_result, output ready);
endinterface

// ===== rtl/core/rmsn_ram.sv =====
// Generic single-port RAM with registered read data.
module rmsn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/rmsn_ctrl.sv =====
// Controller state machine that sequences loading, the inverse root and scaling.
module rmsn_ctrl
    import rmsn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_command,
    input  t_dp_status i_status,
    output logic       o_ready,
    output t_dp_cmd    o_cmd
);
    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_command == CMD_ACCUMULATE) begin
                        if (i_status.acc_done) begin
                            n_state = ST_MEAN_START;
                        end
                    end else if (i_status.scaling) begin
                        n_state = ST_GX;
                    end
                end
            end
            ST_MEAN_START: n_state = ST_DIV_MEAN;
            ST_DIV_MEAN: begin
                if (i_status.div_last) begin
                    n_state = ST_INV_START;
                end
            end
            ST_INV_START: begin
                n_state = i_status.m_zero ? ST_IDLE : ST_DIV_INV;
            end
            ST_DIV_INV: begin
                if (i_status.div_last) begin
                    n_state = ST_SQRT_START;
                end
            end
            ST_SQRT_START: n_state = ST_SQRT;
            ST_SQRT: begin
                if (i_status.sqrt_last) begin
                    n_state = ST_SQRT_END;
                end
            end
            ST_SQRT_END: n_state = ST_IDLE;
            ST_GX:       n_state = ST_MAG;
            ST_MAG:      n_state = ST_OUT;
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    if (i_command == CMD_ACCUMULATE) begin
                        o_cmd.op = OP_ACC;
                    end else if (i_status.scaling) begin
                        o_cmd.op = OP_READ;
                    end
                end
            end
            ST_MEAN_START: o_cmd.op = OP_MEAN_START;
            ST_DIV_MEAN:   o_cmd.op = OP_DIV_STEP;
            ST_INV_START:  o_cmd.op = OP_INV_START;
            ST_DIV_INV:    o_cmd.op = OP_DIV_STEP;
            ST_SQRT_START: o_cmd.op = OP_SQRT_START;
            ST_SQRT:       o_cmd.op = OP_SQRT_STEP;
            ST_SQRT_END:   o_cmd.op = OP_SQRT_END;
            ST_GX:         o_cmd.op = OP_MUL_GX;
            ST_MAG:        o_cmd.op = OP_MUL_INV;
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = OP_OUT;
                end
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end
endmodule

// ===== rtl/core/rmsn_dp.sv =====
// Datapath: element store, square sum, shared divider, square root and scaling pipeline.
module rmsn_dp
    import rmsn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [DATA_W-1:0]     i_element_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [DATA_W-1:0]     o_normalized_value,
    output logic                  o_last_result
);
    logic [LEN_W-1:0]      r_vec_len;
    logic [EPS_W-1:0]      r_eps;
    logic [SUM_W-1:0]      r_sum;
    logic [LEN_W-1:0]      r_load;
    logic [LEN_W-1:0]      r_read;
    logic [INV_W-1:0]      r_inv;
    logic                  r_scaling;
    logic [DIV_W-1:0]      r_dq;
    logic [DVS_W-1:0]      r_rem;
    logic [DVS_W-1:0]      r_dvs;
    logic [DIV_CNT_W-1:0]  r_div_cnt;
    logic [DIV_W-1:0]      r_sq_n;
    logic [DIV_W-1:0]      r_sq_res;
    logic [DIV_W-1:0]      r_sq_bit;
    logic [SQRT_CNT_W-1:0] r_sq_cnt;
    logic [DATA_W-1:0]     r_gain;
    logic signed [31:0]    r_gx;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_value;
    logic                  r_out_last;

    logic [LEN_W-1:0]   eff_len;
    logic [LEN_W-1:0]   eff_load;
    logic [SUM_W-1:0]   eff_sum;
    logic               can_store;
    logic [LEN_W-1:0]   new_load;
    logic signed [31:0] sq;
    logic [LEN_W-1:0]   limit;
    logic [LEN_W-1:0]   read_next;
    logic               is_last;
    logic [DVS_W:0]     trial;
    logic               div_ge;
    logic [DVS_W:0]     div_diff;
    logic [DVS_W-1:0]   m_val;
    logic [DIV_W-1:0]   sq_t;
    logic               sq_ge;
    logic [31:0]        mag;
    logic [63:0]        rnd_sum;
    logic [35:0]        rnd;
    logic [DATA_W-1:0]  sat_value;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [DATA_W-1:0]  ram_rdata;

    // A length of zero acts as one, anything above the store depth acts as the depth.
    always_comb begin
        if (r_vec_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_vec_len > LEN_W'(MAX_LEN)) begin
            eff_len = LEN_W'(MAX_LEN);
        end else begin
            eff_len = r_vec_len;
        end
    end

    // An accumulate item during scaling abandons the vector and starts a new one.
    assign eff_load  = r_scaling ? '0 : r_load;
    assign eff_sum   = r_scaling ? '0 : r_sum;
    assign can_store = eff_load < LEN_W'(MAX_LEN);
    assign new_load  = can_store ? LEN_W'(eff_load + 1'b1) : eff_load;
    assign sq        = $signed(i_element_value) * $signed(i_element_value);

    assign limit     = (r_load < eff_len) ? r_load : eff_len;
    assign read_next = LEN_W'(r_read + 1'b1);
    assign is_last   = read_next >= limit;

    assign trial    = {r_rem, r_dq[DIV_W-1]};
    assign div_ge   = trial >= {1'b0, r_dvs};
    assign div_diff = trial - {1'b0, r_dvs};
    assign m_val    = DVS_W'(r_dq[SUM_W-1:0]) + DVS_W'(r_eps);

    assign sq_t  = r_sq_res + r_sq_bit;
    assign sq_ge = r_sq_n >= sq_t;

    assign mag     = r_gx[31] ? 32'(-r_gx) : 32'(r_gx);
    assign rnd_sum = 64'(r_prod) + (64'(1) << 27);
    assign rnd     = rnd_sum[63:28];

    always_comb begin
        if (r_neg) begin
            sat_value = (rnd >= 36'd32768) ? 16'h8000 : 16'(~rnd[15:0] + 16'd1);
        end else begin
            sat_value = (rnd >= 36'd32767) ? 16'h7FFF : rnd[15:0];
        end
    end

    assign ram_we   = (i_cmd.op == OP_ACC) && can_store;
    assign ram_addr = (i_cmd.op == OP_ACC) ? eff_load[ADDR_W-1:0] : r_read[ADDR_W-1:0];

    rmsn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_element_value),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vec_len   <= VLEN_RESET;
            r_eps       <= EPS_RESET;
            r_sum       <= '0;
            r_load      <= '0;
            r_read      <= '0;
            r_inv       <= '0;
            r_scaling   <= 1'b0;
            r_div_cnt   <= '0;
            r_sq_cnt    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_VECTOR_LENGTH: r_vec_len <= i_cfg_data[LEN_W-1:0];
                    CFG_EPSILON:       r_eps     <= i_cfg_data[EPS_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (i_cmd.op)
                OP_ACC: begin
                    r_scaling <= 1'b0;
                    r_read    <= r_scaling ? '0 : r_read;
                    r_load    <= new_load;
                    r_sum     <= can_store ? SUM_W'(eff_sum + SUM_W'(unsigned'(sq))) : eff_sum;
                end
                OP_MEAN_START: begin
                    r_div_cnt <= '0;
                end
                OP_DIV_STEP: begin
                    r_div_cnt <= DIV_CNT_W'(r_div_cnt + 1'b1);
                end
                OP_INV_START: begin
                    r_div_cnt <= '0;
                    if (m_val == '0) begin
                        r_inv     <= '1;
                        r_scaling <= 1'b1;
                        r_read    <= '0;
                    end
                end
                OP_SQRT_START: begin
                    r_sq_cnt <= '0;
                end
                OP_SQRT_STEP: begin
                    r_sq_cnt <= SQRT_CNT_W'(r_sq_cnt + 1'b1);
                end
                OP_SQRT_END: begin
                    r_inv     <= r_sq_res[INV_W-1:0];
                    r_scaling <= 1'b1;
                    r_read    <= '0;
                end
                OP_OUT: begin
                    if (is_last) begin
                        r_sum     <= '0;
                        r_load    <= '0;
                        r_read    <= '0;
                        r_scaling <= 1'b0;
                    end else begin
                        r_read <= read_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers of the divider, square root and scaling pipeline.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MEAN_START: begin
                r_dq  <= DIV_W'(r_sum);
                r_rem <= '0;
                r_dvs <= DVS_W'(r_load);
            end
            OP_DIV_STEP: begin
                r_rem <= div_ge ? div_diff[DVS_W-1:0] : trial[DVS_W-1:0];
                r_dq  <= {r_dq[DIV_W-2:0], div_ge};
            end
            OP_INV_START: begin
                r_dq  <= DIV_W'(1) << (DIV_W - 1);
                r_rem <= '0;
                r_dvs <= m_val;
            end
            OP_SQRT_START: begin
                r_sq_n   <= r_dq;
                r_sq_res <= '0;
                r_sq_bit <= DIV_W'(1) << (DIV_W - 1);
            end
            OP_SQRT_STEP: begin
                if (sq_ge) begin
                    r_sq_n   <= r_sq_n - sq_t;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
                r_sq_bit <= r_sq_bit >> 2;
            end
            OP_READ: begin
                r_gain <= i_element_value;
            end
            OP_MUL_GX: begin
                r_gx <= $signed(r_gain) * $signed(ram_rdata);
            end
            OP_MUL_INV: begin
                r_prod <= PROD_W'(mag[30:0]) * PROD_W'(r_inv);
                r_neg  <= r_gx[31];
            end
            OP_OUT: begin
                r_out_value <= sat_value;
                r_out_last  <= is_last;
            end
            default: ;
        endcase
    end

    assign o_status.scaling   = r_scaling;
    assign o_status.acc_done  = new_load >= eff_len;
    assign o_status.div_last  = r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1);
    assign o_status.m_zero    = m_val == '0;
    assign o_status.sqrt_last = r_sq_cnt == SQRT_CNT_W'(SQRT_STEPS - 1);
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_normalized_value = r_out_value;
    assign o_last_result      = r_out_last;
endmodule

// ===== rtl/core/rms_normalization_unit.sv =====
// Top level of the RMS normalization unit: controller, datapath and checks.
//
//  Channel    Dir  Handshake          Payload
//  i_items    in   valid / ready      command, element_value (Q4.12)
//  o_results  out  valid / ready      normalized_value (Q4.12), last_result
//  i_cfg_*    in   write enable only  index (0 vector_length, 1 epsilon), data
//
// Items but the last of a vector keep the controller idle: it loads one element per cycle.
// After the last element the inverse root runs two passes of the shared one-bit-per-cycle
// divider and 29 square root steps, or just the first pass if mean plus epsilon is zero.
// A scale item goes through store read, gain product, inverse root product, rounding.
// Reset is synchronous and active low; the element store is not cleared.
// A result waiting in the output register does not hold off input items; only a
// second result that finds the register full stalls until it drains.
module rms_normalization_unit
    import rmsn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rmsn_in_if.sink               i_items,
    rmsn_out_if.source            o_results,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // The controller sequences loading, the inverse root and the scaling pipeline.
    rmsn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_items.valid),
        .i_command (i_items.command),
        .i_status  (dp_status),
        .o_ready   (i_items.ready),
        .o_cmd     (dp_cmd)
    );

    // The datapath holds the element store, the square sum and all arithmetic.
    rmsn_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_status           (dp_status),
        .i_element_value    (i_items.element_value),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_out_ready        (o_results.ready),
        .o_out_valid        (o_results.valid),
        .o_normalized_value (o_results.normalized_value),
        .o_last_result      (o_results.last_result)
    );

    // No item is taken while the divider is running.
    a_no_accept_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.op == OP_DIV_STEP |-> !i_items.ready)
        else $error("input accepted during division");

    // An accumulate item always leaves the block in the loading phase.
    a_acc_clears_scaling : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.op == OP_ACC |=> !dp_status.scaling)
        else $error("scaling phase survived an accumulate item");

    // A result is only written when the output register can take it.
    a_out_has_room : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.op == OP_OUT |-> dp_status.out_free)
        else $error("result written over a pending result");
endmodule
